@@ rtl/brhp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte range header parser package
// Shared types, status and phase codes, character constants and the
// prefix lookup used by the parser modules.
// ----------------------------------------------------------------------------
package brhp_pkg;

    localparam int unsigned MAX_DIGITS_DEF = 19;
    localparam int unsigned VALUE_W        = 64;
    localparam int unsigned DIGIT_W        = 5;
    localparam int unsigned POS_W          = 3;
    localparam int unsigned PREFIX_LEN     = 6;

    // Result status codes.
    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_UNSAT   = 2'd2;
    localparam logic [1:0] ST_OK      = 2'd3;

    // Parser phase codes.
    localparam logic [1:0] PH_PREFIX = 2'd0;
    localparam logic [1:0] PH_START  = 2'd1;
    localparam logic [1:0] PH_END    = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [DIGIT_W-1:0] t_digits;

    // Parser state as seen by the result stage.
    typedef struct packed {
        logic [1:0] phase;
        t_value     start_value;
        t_digits    start_digits;
        t_value     end_value;
        t_digits    end_digits;
        logic       format_bad;
        logic       any_char_seen;
    } t_snap;

    // Expected character of the "bytes=" prefix at a given position.
    function automatic logic [7:0] prefix_char(input logic [POS_W-1:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h62;
            3'd1:    c = 8'h79;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h73;
            3'd5:    c = 8'h3d;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/brhp_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte range header character scanner
// Holds the parse state and folds in one header character per accepted
// transaction. A terminating character returns the state to reset.
// ----------------------------------------------------------------------------
module brhp_scan #(
    parameter int unsigned MAX_DIGITS = brhp_pkg::MAX_DIGITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  logic [7:0]      i_ch,
    output brhp_pkg::t_snap o_state
);
    import brhp_pkg::*;

    logic [POS_W-1:0] r_prefix_pos, n_prefix_pos;
    t_snap            r_st, n_st;
    logic             is_digit;
    t_value           digit_val;

    assign is_digit  = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign digit_val = VALUE_W'(i_ch - CH_ZERO);

    always_comb begin
        n_prefix_pos = r_prefix_pos;
        n_st         = r_st;
        if (i_ch == CH_NUL) begin
            n_prefix_pos = '0;
            n_st         = '0;
            n_st.phase   = PH_PREFIX;
        end else begin
            n_st.any_char_seen = 1'b1;
            if (!r_st.format_bad) begin
                if (r_st.phase == PH_PREFIX) begin
                    if ((32'(r_prefix_pos) < PREFIX_LEN) &&
                        (i_ch == prefix_char(r_prefix_pos))) begin
                        n_prefix_pos = r_prefix_pos + 1'b1;
                        if (32'(r_prefix_pos) == PREFIX_LEN - 1) begin
                            n_st.phase = PH_START;
                        end
                    end else begin
                        n_st.format_bad = 1'b1;
                    end
                end else if (i_ch == CH_COMMA) begin
                    n_st.format_bad = 1'b1;
                end else if ((r_st.phase == PH_START) && (i_ch == CH_DASH)) begin
                    n_st.phase = PH_END;
                end else if (r_st.phase == PH_START) begin
                    if (!is_digit || (r_st.start_digits >= DIGIT_W'(MAX_DIGITS))) begin
                        n_st.format_bad = 1'b1;
                    end else begin
                        n_st.start_value  = (r_st.start_value << 3) +
                                            (r_st.start_value << 1) + digit_val;
                        n_st.start_digits = r_st.start_digits + 1'b1;
                    end
                end else begin
                    if (!is_digit || (r_st.end_digits >= DIGIT_W'(MAX_DIGITS))) begin
                        n_st.format_bad = 1'b1;
                    end else begin
                        n_st.end_value  = (r_st.end_value << 3) +
                                          (r_st.end_value << 1) + digit_val;
                        n_st.end_digits = r_st.end_digits + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_pos <= '0;
            r_st         <= '0;
        end else if (i_load) begin
            r_prefix_pos <= n_prefix_pos;
            r_st         <= n_st;
        end
    end

    assign o_state = r_st;

endmodule

@@ rtl/brhp_resolve.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte range header result stage
// Captures the parse state and resource size at the terminator, works out
// the status and the byte range, and holds the result for the consumer.
// ----------------------------------------------------------------------------
module brhp_resolve (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  brhp_pkg::t_snap  i_snap,
    input  brhp_pkg::t_value i_size,
    input  logic             i_out_stall,
    output logic             o_in_stall,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output brhp_pkg::t_value o_first,
    output brhp_pkg::t_value o_last
);
    import brhp_pkg::*;

    logic       r_f_valid, r_o_valid;
    t_snap      r_snap;
    t_value     r_size;
    logic       f_move;
    logic [1:0] n_status;
    t_value     n_first, n_last;
    t_value     size_m1;
    t_value     cand_last;

    assign f_move     = r_f_valid && (!r_o_valid || !i_out_stall);
    assign o_in_stall = r_f_valid && !f_move;
    assign size_m1    = r_size - 1'b1;

    always_comb begin
        n_status  = ST_OK;
        n_first   = '0;
        n_last    = '0;
        cand_last = '0;
        if (!r_snap.any_char_seen) begin
            n_status = ST_NONE;
        end else if (r_snap.format_bad || (r_snap.phase == PH_PREFIX) ||
                     (r_snap.phase == PH_START)) begin
            n_status = ST_INVALID;
        end else if (r_snap.start_digits == '0) begin
            // Suffix form: the last n bytes of the resource.
            if ((r_snap.end_digits == '0) || (r_snap.end_value == '0)) begin
                n_status = ST_INVALID;
            end else if (r_size == '0) begin
                n_status = ST_UNSAT;
            end else begin
                n_first = (r_snap.end_value >= r_size) ? '0 : (r_size - r_snap.end_value);
                n_last  = size_m1;
            end
        end else begin
            if (r_snap.end_digits == '0) begin
                cand_last = (r_size == '0) ? '0 : size_m1;
            end else begin
                cand_last = r_snap.end_value;
            end
            if ((r_snap.end_digits != '0) && (r_snap.end_value < r_snap.start_value)) begin
                n_status = ST_INVALID;
            end else if (r_snap.start_value >= r_size) begin
                n_status = ST_UNSAT;
            end else begin
                n_first = r_snap.start_value;
                n_last  = (cand_last >= r_size) ? size_m1 : cand_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_f_valid <= i_load || (r_f_valid && !f_move);
            r_o_valid <= f_move || (r_o_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_snap <= i_snap;
            r_size <= i_size;
        end
        if (f_move) begin
            o_status <= n_status;
            o_first  <= n_first;
            o_last   <= n_last;
        end
    end

    assign o_valid = r_o_valid;

endmodule

@@ rtl/byte_range_header_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte range header parser core
// Throughput: one character per cycle while o_stall is low.
// Reset: synchronous, active low; clears the parse state and both result
// stages, so the first character after reset starts a new header.
// ----------------------------------------------------------------------------
// The header arrives one character per transaction. The scanner folds each
// character into the parse state with a compare and a multiply-by-ten
// accumulate, computed combinationally ahead of its register. On the
// terminating zero character the state and the resource size move into
// the result stage, and the scanner starts over for the next header. The
// result stage works out the status and range combinationally and places
// it in the output register, which parts the two channels. The input is
// stalled only when a finished result waits in the output register and
// another terminator already waits behind it.
// ----------------------------------------------------------------------------
module byte_range_header_parser_core #(
    parameter int unsigned MAX_DIGITS = brhp_pkg::MAX_DIGITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Input channel.
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_ch,
    input  brhp_pkg::t_value i_resource_size,
    // Result channel.
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_status,
    output brhp_pkg::t_value o_first_byte,
    output brhp_pkg::t_value o_last_byte
);
    import brhp_pkg::*;

    logic  in_accept;
    logic  term_accept;
    t_snap scan_state;

    // A transaction is taken whenever the source offers one and we do not stall.
    assign in_accept   = i_valid && !o_stall;
    // Only the terminating character produces a result.
    assign term_accept = in_accept && (i_ch == CH_NUL);

    brhp_scan #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_accept),
        .i_ch    (i_ch),
        .o_state (scan_state)
    );

    brhp_resolve u_resolve (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (term_accept),
        .i_snap      (scan_state),
        .i_size      (i_resource_size),
        .i_out_stall (i_stall),
        .o_in_stall  (o_stall),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_first     (o_first_byte),
        .o_last      (o_last_byte)
    );

endmodule
